[sv/pcm_voice_mixer_assert.svh]
// Assertion macros shared by the mixer modules.
// Depends on nothing; included inside module bodies.
`ifndef PCM_VOICE_MIXER_ASSERT_SVH
`define PCM_VOICE_MIXER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PVM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/pvm_pkg.sv]
// Shared types and constants of the PCM voice mixer.
// Used by pvm_front, pvm_back and the pcm_voice_mixer top level.
package pvm_pkg;
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_SLOT   = 3'd2;
  localparam logic [2:0] REQ_OPEN   = 3'd3;
  localparam logic [2:0] REQ_CLOSE  = 3'd4;
  localparam logic [2:0] REQ_SELECT = 3'd5;
  localparam logic [2:0] REQ_MODE   = 3'd6;
  localparam logic [2:0] REQ_SEEK   = 3'd7;

  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_PAUSED = 2'd1;
  localparam logic [1:0] MODE_ONCE   = 2'd2;
  localparam logic [1:0] MODE_LOOP   = 2'd3;

  localparam logic [1:0] PM_ONCE = 2'd1;
  localparam logic [1:0] PM_LOOP = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  stream_level;
    logic [5:0]  voice_index;
    logic [8:0]  slot_index;
    logic [19:0] mem_address;
    logic [7:0]  data_byte;
    logic [15:0] slot_len;
    logic [1:0]  play_mode;
    logic [15:0] seek_point;
    logic        voice_ok;
    logic        slot_ok;
  } cmd_t;
endpackage

[sv/pvm_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
module pvm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                            wdata_i,
  output logic [Width-1:0]                            rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[sv/pvm_front.sv]
// Front end: accepts items, checks index ranges and queues commands.
// Depends on pvm_pkg.
module pvm_front #(
  parameter int NumVoices = 32,
  parameter int NumSlots  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  stream_level_i,
  input  logic [4:0]  voice_index_i,
  input  logic [5:0]  slot_index_i,
  input  logic [15:0] mem_address_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] slot_len_i,
  input  logic [1:0]  play_mode_i,
  input  logic [15:0] seek_point_i,
  output logic        cmd_valid_o,
  input  logic        cmd_take_i,
  output pvm_pkg::cmd_t cmd_o
);
  import pvm_pkg::*;
  `include "pcm_voice_mixer_assert.svh"

  cmd_t      buf_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;
  logic      acc;
  cmd_t      c;

  assign full = (cnt_q == 2'd2);
  assign acc  = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = buf_q[rd_q];

  always_comb begin
    c.req_type     = req_type_i;
    c.stream_level = stream_level_i;
    c.voice_index  = {1'b0, voice_index_i};
    c.slot_index   = {3'b0, slot_index_i};
    c.mem_address  = {4'b0, mem_address_i};
    c.data_byte    = data_byte_i;
    c.slot_len     = slot_len_i;
    c.play_mode    = play_mode_i;
    c.seek_point   = seek_point_i;
    c.voice_ok     = (32'(voice_index_i) < 32'(NumVoices));
    c.slot_ok      = (32'(slot_index_i) < 32'(NumSlots));
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      buf_q[wr_q] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc) begin
        wr_q <= !wr_q;
      end
      if (cmd_take_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take_i);
    end
  end

  `PVM_ASSERT_IMP(a_take_valid, cmd_take_i, cmd_valid_o)
  `PVM_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q != 2'd3)
  `PVM_ASSERT_NEXT(a_full_hold, full && !cmd_take_i, full)
endmodule

[sv/pvm_back.sv]
// Back end: executes commands, walks the voices on a tick and divides.
// Depends on pvm_pkg and pvm_ram.
module pvm_back #(
  parameter int NumVoices = 32,
  parameter int NumSlots  = 64,
  parameter int MemBytes  = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_take_o,
  input  pvm_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  output logic [7:0]    res_level_o,
  output logic [5:0]    res_count_o,
  input  logic          res_free_i
);
  import pvm_pkg::*;
  `include "pcm_voice_mixer_assert.svh"

  localparam int Aw = $clog2(MemBytes);
  localparam int Vw = (NumVoices > 1) ? $clog2(NumVoices) : 1;
  localparam int Sw = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_VOICE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_ACC = 3'd3;
  localparam logic [2:0] ST_DIV = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;
  localparam logic [2:0] ST_SEEK = 3'd6;
  localparam logic [2:0] ST_MOD = 3'd7;

  logic [2:0]  st_q;
  logic [1:0]  mode_q [NumVoices];
  logic [Sw-1:0] vslot_q [NumVoices];
  logic [15:0] voff_q [NumVoices];
  logic [NumSlots-1:0] svld_q;
  logic [Vw-1:0] v_q;
  logic [13:0] sum_q;
  logic [5:0]  cnt_q;
  logic [13:0] rem_q;
  logic [7:0]  quo_q;
  logic [3:0]  bit_q;
  logic        last_q;
  logic [16:0] mr_q;
  logic [4:0]  mb_q;

  logic          mem_we;
  logic [Aw-1:0] mem_addr;
  logic [7:0]    mem_rd;
  logic          slot_we;
  logic [Sw-1:0] slot_addr;
  logic [31:0]   slot_rd;
  logic [15:0]   sbase;
  logic [Vw-1:0] cv;
  logic [Sw-1:0] cs;
  logic          open;
  logic [Sw-1:0] vs;
  logic [15:0]   len;
  logic [16:0]   inc;
  logic [15:0]   nxt;
  logic          vact;
  logic [13:0]   trial;
  logic [5:0]    dvs;
  logic [16:0]   mtr;
  logic [32:0]   msh;
  logic [16:0]   mnx;

  assign cv   = cmd_i.voice_index[Vw-1:0];
  assign cs   = cmd_i.slot_index[Sw-1:0];
  assign open = mode_q[cv] != MODE_CLOSED;
  assign vs   = vslot_q[v_q];
  assign slot_addr = (st_q == ST_IDLE && cmd_i.req_type == REQ_SLOT) ? cs
                   : (st_q == ST_IDLE || st_q == ST_SEEK) ? vslot_q[cv] : vs;
  assign sbase = svld_q[slot_addr] ? slot_rd[31:16] : 16'd0;
  assign len   = svld_q[slot_addr] ? slot_rd[15:0] : 16'd0;
  assign vact = (mode_q[v_q] == MODE_ONCE || mode_q[v_q] == MODE_LOOP) && len != 16'd0;
  assign inc  = 17'(voff_q[v_q]) + 17'd1;
  assign nxt  = (inc == {1'b0, len}) ? 16'd0 : inc[15:0];
  assign dvs  = cnt_q + 6'd1;
  assign trial = rem_q >> bit_q;
  assign mtr  = mr_q >> mb_q;
  assign msh  = {17'b0, len} << mb_q;
  assign mnx  = (mtr >= {1'b0, len}) ? mr_q - msh[16:0] : mr_q;

  assign cmd_take_o = cmd_valid_i &&
                      ((st_q == ST_IDLE && cmd_i.req_type != REQ_SEEK) || st_q == ST_SEEK);
  assign mem_we = cmd_take_o && cmd_i.req_type == REQ_WRITE;
  assign slot_we = cmd_take_o && cmd_i.req_type == REQ_SLOT && cmd_i.slot_ok;
  assign mem_addr = (st_q == ST_IDLE) ? cmd_i.mem_address[Aw-1:0]
                  : Aw'(32'(sbase) + 32'(voff_q[v_q]));

  pvm_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(cmd_i.data_byte),
    .rdata_o(mem_rd)
  );

  pvm_ram #(.Width(32), .Depth(NumSlots)) u_slot (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .addr_i (slot_addr),
    .wdata_i({cmd_i.mem_address[15:0], cmd_i.slot_len}),
    .rdata_o(slot_rd)
  );

  assign res_valid_o = st_q == ST_OUT;
  assign res_level_o = quo_q;
  assign res_count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      v_q <= '0;
      last_q <= 1'b0;
      sum_q <= '0;
      cnt_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      bit_q <= '0;
      mr_q <= '0;
      mb_q <= '0;
      svld_q <= '0;
      for (int i = 0; i < NumVoices; i++) begin
        mode_q[i] <= MODE_CLOSED;
        vslot_q[i] <= '0;
        voff_q[i] <= '0;
      end
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_i.req_type == REQ_SEEK) begin
            st_q <= ST_SEEK;
          end
          if (cmd_take_o) begin
            case (cmd_i.req_type)
              REQ_TICK: begin
                st_q <= ST_VOICE;
                v_q <= '0;
                last_q <= (NumVoices == 1);
                sum_q <= {6'b0, cmd_i.stream_level};
                cnt_q <= '0;
              end
              REQ_SLOT: begin
                if (cmd_i.slot_ok) begin
                  svld_q[cs] <= 1'b1;
                end
              end
              REQ_OPEN: begin
                if (cmd_i.voice_ok && !open) begin
                  mode_q[cv] <= MODE_PAUSED;
                  vslot_q[cv] <= '0;
                  voff_q[cv] <= '0;
                end
              end
              REQ_CLOSE: begin
                if (cmd_i.voice_ok && open) begin
                  mode_q[cv] <= MODE_CLOSED;
                  vslot_q[cv] <= '0;
                  voff_q[cv] <= '0;
                end
              end
              REQ_SELECT: begin
                if (cmd_i.voice_ok && open && cmd_i.slot_ok) begin
                  vslot_q[cv] <= cs;
                  voff_q[cv] <= '0;
                end
              end
              REQ_MODE: begin
                if (cmd_i.voice_ok && open) begin
                  mode_q[cv] <= (cmd_i.play_mode == PM_ONCE) ? MODE_ONCE
                              : (cmd_i.play_mode == PM_LOOP) ? MODE_LOOP : MODE_PAUSED;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SEEK: begin
          if (cmd_i.voice_ok && open && len != 16'd0) begin
            voff_q[cv] <= (cmd_i.seek_point < len) ? cmd_i.seek_point : len - 16'd1;
          end
          st_q <= ST_IDLE;
        end
        ST_VOICE: begin
          st_q <= ST_READ;
        end
        ST_READ: begin
          st_q <= ST_ACC;
        end
        ST_ACC: begin
          if (vact) begin
            sum_q <= sum_q + {6'b0, mem_rd};
            cnt_q <= cnt_q + 6'd1;
          end
          if (vact && inc > {1'b0, len}) begin
            st_q <= ST_MOD;
            mr_q <= inc;
            mb_q <= 5'd16;
          end else begin
            if (vact) begin
              voff_q[v_q] <= nxt;
              if (nxt == 16'd0 && mode_q[v_q] == MODE_ONCE) begin
                mode_q[v_q] <= MODE_PAUSED;
              end
            end
            if (last_q) begin
              st_q <= ST_DIV;
              rem_q <= sum_q + (vact ? {6'b0, mem_rd} : 14'd0);
              bit_q <= 4'd7;
              quo_q <= '0;
            end else begin
              st_q <= ST_VOICE;
              v_q <= v_q + Vw'(1);
              last_q <= (32'(v_q) + 2 == NumVoices);
            end
          end
        end
        ST_MOD: begin
          if (mb_q == 5'd0) begin
            voff_q[v_q] <= mnx[15:0];
            if (mnx == 17'd0 && mode_q[v_q] == MODE_ONCE) begin
              mode_q[v_q] <= MODE_PAUSED;
            end
            if (last_q) begin
              st_q <= ST_DIV;
              rem_q <= sum_q;
              bit_q <= 4'd7;
              quo_q <= '0;
            end else begin
              st_q <= ST_VOICE;
              v_q <= v_q + Vw'(1);
              last_q <= (32'(v_q) + 2 == NumVoices);
            end
          end else begin
            mr_q <= mnx;
            mb_q <= mb_q - 5'd1;
          end
        end
        ST_DIV: begin
          if (trial >= {8'b0, dvs}) begin
            rem_q <= rem_q - 14'(({8'b0, dvs} << bit_q));
            quo_q[bit_q[2:0]] <= 1'b1;
          end
          if (bit_q == 4'd0) begin
            st_q <= ST_OUT;
          end
          bit_q <= bit_q - 4'd1;
        end
        ST_OUT: begin
          if (res_free_i) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  `PVM_ASSERT_IMP(a_take_idle, cmd_take_o, st_q == ST_IDLE || st_q == ST_SEEK)
  `PVM_ASSERT_IMP(a_seek_valid, st_q == ST_SEEK, cmd_valid_i)
  `PVM_ASSERT_IMP(a_cnt_max, 1'b1, 32'(cnt_q) <= NumVoices)
  `PVM_ASSERT_NEXT(a_out_hold, res_valid_o && !res_free_i, res_valid_o && $stable(quo_q))
endmodule

[sv/pcm_voice_mixer.sv]
// Eight-bit multi-voice PCM mixer top level with a one-entry output register.
// Depends on pvm_pkg, pvm_front, pvm_back and pvm_ram.
// A tick item is taken in idle; each voice passes through the voice, read and accumulate
// states for the slot table and sample-memory reads, the restoring divider forms the
// eight-bit quotient and the result waits for the output register. A playing voice whose
// offset lies at or past the end of a slot that was shortened under it adds the mod state
// for the remainder. A seek item takes the seek state for its slot lookup; others
// are taken in idle. A two-entry command queue lets items enter while a tick is busy.
module pcm_voice_mixer #(
  parameter int NUM_VOICES = 32,
  parameter int NUM_SLOTS = 64,
  parameter int SAMPLE_MEM_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  stream_level_i,
  input  logic [4:0]  voice_index_i,
  input  logic [5:0]  slot_index_i,
  input  logic [15:0] mem_address_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] slot_len_i,
  input  logic [1:0]  play_mode_i,
  input  logic [15:0] seek_point_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  mixed_level_o,
  output logic [5:0]  active_voices_o
);
  import pvm_pkg::*;

  logic cmd_valid, cmd_take, res_valid, res_free, out_q;
  cmd_t cmd;
  logic [7:0] lvl;
  logic [5:0] cnt;

  pvm_front #(.NumVoices(NUM_VOICES), .NumSlots(NUM_SLOTS)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .req_type_i, .stream_level_i, .voice_index_i, .slot_index_i, .mem_address_i,
    .data_byte_i, .slot_len_i, .play_mode_i, .seek_point_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  pvm_back #(.NumVoices(NUM_VOICES), .NumSlots(NUM_SLOTS),
             .MemBytes(SAMPLE_MEM_BYTES)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .res_valid_o(res_valid), .res_level_o(lvl), .res_count_o(cnt), .res_free_i(res_free)
  );

  assign res_free = !out_q || pop;
  assign empty = !out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= 1'b0;
    end else if (res_free) begin
      out_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      mixed_level_o <= lvl;
      active_voices_o <= cnt;
    end
  end
endmodule

[verif/pcm_voice_mixer_test.sv]
// Self-checking testbench for pcm_voice_mixer: it drives request items on the push side,
// pops mix results, and compares them against an internal model of voices, slots and memory.
// Depends on pvm_pkg and the pcm_voice_mixer RTL.
module pcm_voice_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pvm_pkg::*;

  localparam int VOICES = 32;
  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [2:0]  req_type;
    logic [7:0]  stream_level;
    logic [4:0]  voice_index;
    logic [5:0]  slot_index;
    logic [15:0] mem_address;
    logic [7:0]  data_byte;
    logic [15:0] slot_len;
    logic [1:0]  play_mode;
    logic [15:0] seek_point;
  } request_t;

  typedef struct {
    logic [7:0] level;
    logic [5:0] count;
  } mix_t;

  class mix_scoreboard;
    logic [7:0]  mem [0:65535];
    bit          written [0:65535];
    logic [15:0] base [0:SLOTS-1];
    logic [15:0] size [0:SLOTS-1];
    logic [1:0]  mode [0:VOICES-1];
    logic [5:0]  vslot [0:VOICES-1];
    logic [15:0] offset [0:VOICES-1];
    mix_t        pending [$];
    int          mismatches;

    function new();
      mismatches = 0;
      foreach (base[i]) begin
        base[i] = '0;
        size[i] = '0;
      end
      foreach (mode[i]) begin
        mode[i] = MODE_CLOSED;
        vslot[i] = '0;
        offset[i] = '0;
      end
    endfunction

    function bit plays(int v);
      return mode[v] >= MODE_ONCE && size[vslot[v]] != 0;
    endfunction

    function logic [15:0] read_addr(int v);
      return base[vslot[v]] + offset[v];
    endfunction

    function void note_item(request_t r);
      logic [13:0] sum;
      logic [5:0]  cnt;
      logic [16:0] nxt;
      logic [15:0] len;
      mix_t        m;
      bit          open;
      open = mode[r.voice_index] != MODE_CLOSED;
      case (r.req_type)
        REQ_TICK: begin
          sum = 14'(r.stream_level);
          cnt = '0;
          for (int v = 0; v < VOICES; v++) begin
            if (plays(v)) begin
              len = size[vslot[v]];
              sum += 14'(mem[read_addr(v)]);
              cnt++;
              nxt = (offset[v] + 17'd1) % len;
              offset[v] = nxt[15:0];
              if (nxt == 0 && mode[v] == MODE_ONCE) mode[v] = MODE_PAUSED;
            end
          end
          m.level = 8'(sum / (14'(cnt) + 14'd1));
          m.count = cnt;
          pending.push_back(m);
        end
        REQ_WRITE: begin
          mem[r.mem_address] = r.data_byte;
          written[r.mem_address] = 1'b1;
        end
        REQ_SLOT: begin
          base[r.slot_index] = r.mem_address;
          size[r.slot_index] = r.slot_len;
        end
        REQ_OPEN: begin
          if (!open) begin
            mode[r.voice_index] = MODE_PAUSED;
            vslot[r.voice_index] = '0;
            offset[r.voice_index] = '0;
          end
        end
        REQ_CLOSE: begin
          if (open) begin
            mode[r.voice_index] = MODE_CLOSED;
            vslot[r.voice_index] = '0;
            offset[r.voice_index] = '0;
          end
        end
        REQ_SELECT: begin
          if (open) begin
            vslot[r.voice_index] = r.slot_index;
            offset[r.voice_index] = '0;
          end
        end
        REQ_MODE: begin
          if (open) begin
            if (r.play_mode == PM_ONCE) mode[r.voice_index] = MODE_ONCE;
            else if (r.play_mode == PM_LOOP) mode[r.voice_index] = MODE_LOOP;
            else mode[r.voice_index] = MODE_PAUSED;
          end
        end
        default: begin
          len = size[vslot[r.voice_index]];
          if (open && len != 0)
            offset[r.voice_index] = (r.seek_point < len) ? r.seek_point : len - 16'd1;
        end
      endcase
    endfunction

    function void check_mix(logic [7:0] level, logic [5:0] count);
      mix_t m;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: level %0d count %0d", level, count);
      end else begin
        m = pending.pop_front();
        if (level !== m.level || count !== m.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mix mismatch: expected level %0d count %0d, got level %0d count %0d",
                     m.level, m.count, level, count);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  req_type_i = '0;
  logic [7:0]  stream_level_i = '0;
  logic [4:0]  voice_index_i = '0;
  logic [5:0]  slot_index_i = '0;
  logic [15:0] mem_address_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [15:0] slot_len_i = '0;
  logic [1:0]  play_mode_i = '0;
  logic [15:0] seek_point_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  mixed_level_o;
  logic [5:0]  active_voices_o;

  mix_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;

  pcm_voice_mixer dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_mix(mixed_level_o, active_voices_o);
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_item(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    req_type_i <= r.req_type;
    stream_level_i <= r.stream_level;
    voice_index_i <= r.voice_index;
    slot_index_i <= r.slot_index;
    mem_address_i <= r.mem_address;
    data_byte_i <= r.data_byte;
    slot_len_i <= r.slot_len;
    play_mode_i <= r.play_mode;
    seek_point_i <= r.seek_point;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_item(r);
  endtask

  // Before a tick, any byte that a playing voice would read is written first.
  task automatic send_item(request_t r);
    request_t w;
    logic [15:0] a;
    if (r.req_type == REQ_TICK) begin
      for (int v = 0; v < VOICES; v++) begin
        if (sb.plays(v)) begin
          a = sb.read_addr(v);
          if (!sb.written[a]) begin
            w = r;
            w.req_type = REQ_WRITE;
            w.mem_address = a;
            w.data_byte = 8'($urandom_range(255));
            push_item(w);
          end
        end
      end
    end
    push_item(r);
  endtask

  function automatic request_t make_req(logic [2:0] kind);
    request_t r;
    r.req_type = kind;
    r.stream_level = 8'($urandom_range(255));
    r.voice_index = 5'(($urandom_range(1) != 0) ? $urandom_range(7) : $urandom_range(31));
    r.slot_index = 6'(($urandom_range(1) != 0) ? $urandom_range(7) : $urandom_range(63));
    r.mem_address = 16'($urandom_range(65535));
    r.data_byte = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: r.slot_len = 16'd0;
      1: r.slot_len = 16'($urandom_range(65535));
      default: r.slot_len = 16'($urandom_range(24, 1));
    endcase
    r.play_mode = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    r.seek_point = 16'(($urandom_range(1) != 0) ? $urandom_range(65535) : $urandom_range(30));
    return r;
  endfunction

  function automatic request_t random_req();
    int p;
    p = int'($urandom_range(99));
    if (p < 35) return make_req(REQ_TICK);
    if (p < 43) return make_req(REQ_WRITE);
    if (p < 53) return make_req(REQ_SLOT);
    if (p < 65) return make_req(REQ_OPEN);
    if (p < 69) return make_req(REQ_CLOSE);
    if (p < 78) return make_req(REQ_SELECT);
    if (p < 92) return make_req(REQ_MODE);
    return make_req(REQ_SEEK);
  endfunction

  task automatic directed();
    request_t r;
    r = make_req(REQ_WRITE); r.mem_address = 16'hFFFF; r.data_byte = 8'hFF; send_item(r);
    r = make_req(REQ_WRITE); r.mem_address = 16'h0000; r.data_byte = 8'h00; send_item(r);
    r = make_req(REQ_TICK); r.stream_level = 8'hFF; send_item(r);
    r = make_req(REQ_SLOT); r.slot_index = 6'd63; r.mem_address = 16'hFFFE;
    r.slot_len = 16'd4; send_item(r);
    r = make_req(REQ_SLOT); r.slot_index = 6'd0; r.mem_address = 16'h0000;
    r.slot_len = 16'hFFFF; send_item(r);
    r = make_req(REQ_MODE); r.voice_index = 5'd31; r.play_mode = PM_LOOP; send_item(r);
    r = make_req(REQ_OPEN); r.voice_index = 5'd31; send_item(r);
    r = make_req(REQ_OPEN); r.voice_index = 5'd0; send_item(r);
    r = make_req(REQ_OPEN); r.voice_index = 5'd31; send_item(r);
    r = make_req(REQ_SELECT); r.voice_index = 5'd31; r.slot_index = 6'd63; send_item(r);
    r = make_req(REQ_SEEK); r.voice_index = 5'd31; r.seek_point = 16'hFFFF; send_item(r);
    r = make_req(REQ_MODE); r.voice_index = 5'd31; r.play_mode = PM_ONCE; send_item(r);
    r = make_req(REQ_MODE); r.voice_index = 5'd0; r.play_mode = PM_LOOP; send_item(r);
    r = make_req(REQ_TICK); r.stream_level = 8'h00; send_item(r);
    r = make_req(REQ_TICK); r.stream_level = 8'hFF; send_item(r);
    r = make_req(REQ_SLOT); r.slot_index = 6'd63; r.slot_len = 16'd2; send_item(r);
    r = make_req(REQ_MODE); r.voice_index = 5'd31; r.play_mode = 2'd3; send_item(r);
    r = make_req(REQ_SELECT); r.voice_index = 5'd0; r.slot_index = 6'd5; send_item(r);
    r = make_req(REQ_SEEK); r.voice_index = 5'd0; r.seek_point = 16'd3; send_item(r);
    r = make_req(REQ_TICK); send_item(r);
    r = make_req(REQ_CLOSE); r.voice_index = 5'd0; send_item(r);
    r = make_req(REQ_CLOSE); r.voice_index = 5'd0; send_item(r);
    r = make_req(REQ_SELECT); r.voice_index = 5'd0; send_item(r);
    r = make_req(REQ_TICK); send_item(r);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 32;
    recv_idle_pct = 83;
    directed();
    for (int i = 0; i < 750; i++) begin
      if (i == 250) begin
        send_idle_pct = 83;
        recv_idle_pct = 32;
      end else if (i == 500) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_item(random_req());
    end
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
